>>> rtl/core/rle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants of the run/literal byte-stream decoder.
// ----------------------------------------------------------------------------
package rle_pkg;

  localparam int unsigned OutLanes    = 8;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 9;
  localparam int unsigned LaneCntW    = 4;
  localparam int unsigned WordW       = 64;
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned FifoPtrW    = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW    = $clog2(FifoDepth + 1);
  localparam logic [ByteW-1:0] CutoffReset = 8'd128;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_RUN     = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef enum logic {
    CMD_EXPAND = 1'b0,
    CMD_ERROR  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             stream_last;
  } rle_in_t;

  typedef struct packed {
    logic [WordW-1:0]    out_bytes;
    logic [LaneCntW-1:0] lane_count;
    logic                item_last;
    logic                stream_end;
    logic                decode_error;
  } rle_out_t;

  // one classified item handed from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic             last;
  } rle_cmd_t;

endpackage

>>> rtl/core/rle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_front
// Accepts compressed bytes, tracks control/run/literal phase and pushes one
// expand or error command per byte that produces output.
// ----------------------------------------------------------------------------
module rle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  rle_pkg::rle_in_t  in_data_i,
  output logic              in_stall_o,
  input  logic              fifo_full_i,
  output logic              push_o,
  output rle_pkg::rle_cmd_t cmd_o
);
  import rle_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [ByteW-1:0] cutoff_q;
  logic             accept;
  logic [LenW-1:0]  byte_ext;
  logic [LenW-1:0]  cut_ext;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign byte_ext   = {1'b0, in_data_i.in_byte};
  assign cut_ext    = {1'b0, cutoff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CutoffReset;
    end else if (cfg_valid_i) begin
      cutoff_q <= cfg_data_i;
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (accept) begin
      unique case (phase_q)
        PH_RUN: begin
          phase_d = PH_CONTROL;
          count_d = '0;
        end
        PH_LITERAL: begin
          if (in_data_i.stream_last) begin
            phase_d = PH_CONTROL;
            count_d = '0;
          end else begin
            count_d = (count_q != '0) ? count_q - LenW'(1) : '0;
            if (count_d == '0) begin
              phase_d = PH_CONTROL;
            end
          end
        end
        default: begin
          if (in_data_i.stream_last) begin
            phase_d = PH_CONTROL;
            count_d = '0;
          end else if (in_data_i.in_byte <= cutoff_q) begin
            phase_d = PH_RUN;
            count_d = byte_ext + LenW'(1);
          end else begin
            phase_d = PH_LITERAL;
            count_d = byte_ext - cut_ext + LenW'(1);
          end
        end
      endcase
    end
  end

  // command outputs
  always_comb begin
    push_o      = 1'b0;
    cmd_o.kind  = CMD_EXPAND;
    cmd_o.data  = in_data_i.in_byte;
    cmd_o.len   = LenW'(1);
    cmd_o.last  = in_data_i.stream_last;
    unique case (phase_q)
      PH_RUN: begin
        push_o    = accept;
        cmd_o.len = count_q;
      end
      PH_LITERAL: begin
        push_o     = accept;
        cmd_o.kind = in_data_i.stream_last ? CMD_ERROR : CMD_EXPAND;
      end
      default: begin
        push_o     = accept && in_data_i.stream_last;
        cmd_o.kind = CMD_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CONTROL;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  a_lit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LITERAL |-> count_q != '0)
    else $error("literal phase with empty count");

  a_run_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RUN |-> count_q != '0)
    else $error("run armed with zero length");

  a_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !fifo_full_i)
    else $error("command pushed into full queue");

endmodule

>>> rtl/core/rle_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_cmd_fifo
// Short command queue between the front and the back of the decoder.
// ----------------------------------------------------------------------------
module rle_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rle_pkg::rle_cmd_t wdata_i,
  input  logic              pop_i,
  output rle_pkg::rle_cmd_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import rle_pkg::*;

  rle_cmd_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [FifoCntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rptr_q + FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue underflow");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue count out of range");

endmodule

>>> rtl/core/rle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_back
// Pops commands and expands them into packed lane words, one word a cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module rle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rle_pkg::rle_cmd_t cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rle_pkg::rle_out_t out_data_o
);
  import rle_pkg::*;

  logic             act_q, act_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  rle_out_t         out_q, out_d;

  logic             load, go;
  rle_cmd_t         src;
  logic [LenW-1:0]  cnt, rem;
  logic [WordW-1:0] word;

  assign load  = !out_valid_q || !out_stall_i;
  assign go    = load && (act_q || !empty_i);
  assign pop_o = load && !act_q && !empty_i;

  // continue the active run, else start the queue head
  always_comb begin
    if (act_q) begin
      src.kind = CMD_EXPAND;
      src.data = byte_q;
      src.len  = left_q;
      src.last = last_q;
    end else begin
      src = cmd_i;
    end
  end

  always_comb begin
    cnt = (src.len > LenW'(OutLanes)) ? LenW'(OutLanes) : src.len;
    rem = src.len - cnt;
    word = '0;
    for (int unsigned k = 0; k < OutLanes; k++) begin
      if (LenW'(k) < cnt) begin
        word[k*ByteW +: ByteW] = src.data;
      end
    end
  end

  always_comb begin
    act_d       = act_q;
    left_d      = left_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = go;
    end
    if (go) begin
      if (src.kind == CMD_ERROR) begin
        out_d.out_bytes    = '0;
        out_d.lane_count   = '0;
        out_d.item_last    = 1'b1;
        out_d.stream_end   = 1'b1;
        out_d.decode_error = 1'b1;
        act_d              = 1'b0;
      end else begin
        out_d.out_bytes    = word;
        out_d.lane_count   = cnt[LaneCntW-1:0];
        out_d.item_last    = (rem == '0);
        out_d.stream_end   = (rem == '0) && src.last;
        out_d.decode_error = 1'b0;
        act_d              = (rem != '0);
      end
      left_d = rem;
      byte_d = src.data;
      last_d = src.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q <= left_d;
    byte_q <= byte_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.decode_error |->
      out_q.lane_count == '0 && out_q.item_last && out_q.stream_end)
    else $error("malformed error beat");

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.stream_end |-> out_q.item_last)
    else $error("stream end without item end");

  a_more_to_come : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.item_last |-> act_q)
    else $error("partial run beat with nothing pending");

  a_active_left : assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> left_q != '0)
    else $error("active run with no bytes left");

endmodule

>>> rtl/core/rle_run_literal_decoder.sv
`timescale 1ns / 1ps
// Path: a byte's command goes through the command queue into the registered output stage.
// Throughput: one byte a cycle unless the queue is full; control bytes give no beat unless
//   they end the stream, literal and error bytes one beat, a run of length n ceil(n/8) beats.
// A two-entry command queue lets the input keep flowing while a run is expanded.
// Reset clears phase, counts, queue and output valid; the cutoff resets to 128.
// ----------------------------------------------------------------------------
// rle_run_literal_decoder
// Run/literal byte-stream decoder: front classifier, command queue, expander.
// ----------------------------------------------------------------------------
module rle_run_literal_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rle_pkg::rle_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rle_pkg::rle_out_t out_data_o
);
  import rle_pkg::*;

  rle_cmd_t push_cmd, head_cmd;
  logic     push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  rle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  rle_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  rle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
